[rtl/tick_count_job_table_assert.svh]
// Assertion macros shared by the job table RTL.
// Expects a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef TICK_COUNT_JOB_TABLE_ASSERT_SVH
`define TICK_COUNT_JOB_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TCJT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TCJT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tcjt_pkg.sv]
// Shared types and codes for the tick count job table.
// No dependencies; imported by the front end, the executor and the top level.
`timescale 1ns / 1ps

package tcjt_pkg;

    // Input item
    typedef struct packed {
        logic [2:0]  opcode;
        logic [5:0]  slot;
        logic [15:0] target_count;
    } t_in;

    // Result item
    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] slot_number;
        logic [6:0] fired_count;
        logic       last;
    } t_out;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_ADD_ONCE = 3'd1;
    localparam logic [2:0] OP_ADD_PERS = 3'd2;
    localparam logic [2:0] OP_DELETE   = 3'd3;
    localparam logic [2:0] OP_ENABLE   = 3'd4;
    localparam logic [2:0] OP_DISABLE  = 3'd5;

    localparam logic [2:0] KIND_ADDED    = 3'd0;
    localparam logic [2:0] KIND_FULL     = 3'd1;
    localparam logic [2:0] KIND_CTL_OK   = 3'd2;
    localparam logic [2:0] KIND_CTL_FAIL = 3'd3;
    localparam logic [2:0] KIND_FIRED    = 3'd4;
    localparam logic [2:0] KIND_DONE     = 3'd5;

    typedef enum logic [1:0] {
        CLS_TICK,
        CLS_ADD,
        CLS_CTRL,
        CLS_BAD
    } t_cls;

    typedef enum logic [1:0] {
        CTL_DEL,
        CTL_EN,
        CTL_DIS
    } t_ctl;

    // Classified command passed from the front end to the executor
    typedef struct packed {
        t_cls        cls;
        logic        persist;
        t_ctl        cop;
        logic        in_range;
        logic [5:0]  slot;
        logic [15:0] target;
    } t_cmd;

endpackage

[rtl/tcjt_fifo.sv]
// Small synchronous queue of WIDTH-bit entries, power-of-two depth.
// No dependencies; used for the command queue and the result queue.
`timescale 1ns / 1ps

module tcjt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [NW-1:0] DEPTH_C = NW'(DEPTH);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [NW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == DEPTH_C);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_buf[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= PW'(r_wp + 1'b1);
            end
            if (do_pop) begin
                r_rp <= PW'(r_rp + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= NW'(r_cnt + 1'b1);
            end else if (do_pop && !do_push) begin
                r_cnt <= NW'(r_cnt - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

endmodule

[rtl/tcjt_front.sv]
// Front end: decodes an input item into a classified command for the queue.
// Depends on tcjt_pkg.
`timescale 1ns / 1ps

module tcjt_front #(
    parameter int SLOTS = 16
) (
    input  tcjt_pkg::t_in  i_item,
    input  logic           i_push,
    output logic           o_full,
    output tcjt_pkg::t_cmd o_cmd,
    output logic           o_cmd_push,
    input  logic           i_cmd_full
);
    import tcjt_pkg::*;

    logic in_range;

    assign in_range   = ({1'b0, i_item.slot} < 7'(SLOTS));
    assign o_full     = i_cmd_full;
    assign o_cmd_push = i_push;

    always_comb begin
        o_cmd          = '0;
        o_cmd.target   = i_item.target_count;
        o_cmd.in_range = in_range;
        unique case (i_item.opcode)
            OP_TICK: begin
                o_cmd.cls = CLS_TICK;
            end
            OP_ADD_ONCE: begin
                o_cmd.cls = CLS_ADD;
            end
            OP_ADD_PERS: begin
                o_cmd.cls     = CLS_ADD;
                o_cmd.persist = 1'b1;
            end
            OP_DELETE: begin
                o_cmd.cls  = CLS_CTRL;
                o_cmd.cop  = CTL_DEL;
                o_cmd.slot = i_item.slot;
            end
            OP_ENABLE: begin
                o_cmd.cls  = CLS_CTRL;
                o_cmd.cop  = CTL_EN;
                o_cmd.slot = i_item.slot;
            end
            OP_DISABLE: begin
                o_cmd.cls  = CLS_CTRL;
                o_cmd.cop  = CTL_DIS;
                o_cmd.slot = i_item.slot;
            end
            default: begin
                // unknown opcode: fail with slot zero
                o_cmd.cls = CLS_BAD;
            end
        endcase
    end

endmodule

[rtl/tcjt_back.sv]
// Executor: holds the slot table and runs ticks, adds and control commands.
// Depends on tcjt_pkg and tick_count_job_table_assert.svh.
`timescale 1ns / 1ps

module tcjt_back #(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcjt_pkg::t_cmd i_cmd,
    input  logic           i_cmd_empty,
    output logic           o_cmd_pop,
    output tcjt_pkg::t_out o_res,
    output logic           o_res_push,
    input  logic           i_res_full
);
    import tcjt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MW = 2 * COUNT_BITS;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_ADD,
        S_CTRL
    } t_state;

    t_state          r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_pv, n_pv;
    logic [IW-1:0]   r_pidx, n_pidx;
    logic [6:0]      r_fired, n_fired;
    logic [SLOTS-1:0] r_active, n_active;
    logic [SLOTS-1:0] r_enabled, n_enabled;
    logic [SLOTS-1:0] r_persist, n_persist;

    // target in the upper half, count in the lower half
    logic [MW-1:0]   r_mem [SLOTS];
    logic [MW-1:0]   r_rd;

    logic            mem_we;
    logic [IW-1:0]   mem_wa;
    logic [MW-1:0]   mem_wd;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;

    logic [COUNT_BITS-1:0] rd_tgt;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic            p_elig;
    logic            fire;
    logic [IW-1:0]   sidx;
    logic [IW-1:0]   aidx;

    assign rd_tgt = r_rd[MW-1:COUNT_BITS];
    assign rd_cnt = r_rd[COUNT_BITS-1:0];
    assign p_elig = r_pv && r_active[r_pidx] && r_enabled[r_pidx];
    assign fire   = (rd_cnt >= rd_tgt);
    assign sidx   = IW'(r_cmd.slot);
    assign aidx   = r_idx[IW-1:0];

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_pv       = r_pv;
        n_pidx     = r_pidx;
        n_fired    = r_fired;
        n_active   = r_active;
        n_enabled  = r_enabled;
        n_persist  = r_persist;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        o_res.last = 1'b1;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = '0;
        rd_en      = 1'b0;
        rd_addr    = aidx;

        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_idx     = '0;
                    n_pv      = 1'b0;
                    n_fired   = '0;
                    unique case (i_cmd.cls)
                        CLS_TICK: n_state = S_TICK;
                        CLS_ADD:  n_state = S_ADD;
                        default:  n_state = S_CTRL;
                    endcase
                end
            end

            S_TICK: begin
                if (!r_pv && r_idx == SLOTS_C) begin
                    // scan drained: close the tick
                    if (!i_res_full) begin
                        o_res_push        = 1'b1;
                        o_res.kind        = KIND_DONE;
                        o_res.fired_count = r_fired;
                        n_state           = S_IDLE;
                    end
                end else if (!(p_elig && fire && i_res_full)) begin
                    // evaluate the slot whose read was issued last
                    if (p_elig) begin
                        mem_wa = r_pidx;
                        if (fire) begin
                            o_res_push        = 1'b1;
                            o_res.kind        = KIND_FIRED;
                            o_res.slot_number = 6'(r_pidx);
                            o_res.last        = 1'b0;
                            n_fired           = 7'(r_fired + 7'd1);
                            if (r_persist[r_pidx]) begin
                                mem_we = 1'b1;
                                mem_wd = {rd_tgt, {COUNT_BITS{1'b0}}};
                            end else begin
                                n_active[r_pidx]  = 1'b0;
                                n_enabled[r_pidx] = 1'b0;
                                n_persist[r_pidx] = 1'b0;
                            end
                        end else begin
                            mem_we = 1'b1;
                            mem_wd = {rd_tgt, COUNT_BITS'(rd_cnt + 1'b1)};
                        end
                    end
                    // issue the next read
                    if (r_idx != SLOTS_C) begin
                        rd_en  = 1'b1;
                        n_pv   = 1'b1;
                        n_pidx = aidx;
                        n_idx  = CW'(r_idx + 1'b1);
                    end else begin
                        n_pv = 1'b0;
                    end
                end
            end

            S_ADD: begin
                if (r_idx == SLOTS_C) begin
                    if (!i_res_full) begin
                        o_res_push = 1'b1;
                        o_res.kind = KIND_FULL;
                        n_state    = S_IDLE;
                    end
                end else if (!r_active[aidx]) begin
                    if (!i_res_full) begin
                        o_res_push        = 1'b1;
                        o_res.kind        = KIND_ADDED;
                        o_res.slot_number = 6'(aidx);
                        mem_we            = 1'b1;
                        mem_wa            = aidx;
                        mem_wd            = {COUNT_BITS'(r_cmd.target), {COUNT_BITS{1'b0}}};
                        n_active[aidx]    = 1'b1;
                        n_enabled[aidx]   = 1'b1;
                        n_persist[aidx]   = r_cmd.persist;
                        n_state           = S_IDLE;
                    end
                end else begin
                    n_idx = CW'(r_idx + 1'b1);
                end
            end

            S_CTRL: begin
                if (!i_res_full) begin
                    o_res_push        = 1'b1;
                    o_res.slot_number = r_cmd.slot;
                    n_state           = S_IDLE;
                    if (r_cmd.cls == CLS_CTRL && r_cmd.in_range && r_active[sidx]) begin
                        o_res.kind = KIND_CTL_OK;
                        unique case (r_cmd.cop)
                            CTL_DEL: begin
                                n_active[sidx]  = 1'b0;
                                n_enabled[sidx] = 1'b0;
                                n_persist[sidx] = 1'b0;
                            end
                            CTL_EN:  n_enabled[sidx] = 1'b1;
                            default: n_enabled[sidx] = 1'b0;
                        endcase
                    end else begin
                        o_res.kind = KIND_CTL_FAIL;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pv      <= 1'b0;
            r_active  <= '0;
            r_enabled <= '0;
            r_persist <= '0;
        end else begin
            r_state   <= n_state;
            r_pv      <= n_pv;
            r_active  <= n_active;
            r_enabled <= n_enabled;
            r_persist <= n_persist;
        end
        r_cmd   <= n_cmd;
        r_idx   <= n_idx;
        r_pidx  <= n_pidx;
        r_fired <= n_fired;
    end

    // target/count store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

`include "tick_count_job_table_assert.svh"

    `TCJT_ASSERT_NOW(a_no_push_full, o_res_push, !i_res_full, "result pushed into full queue")
    `TCJT_ASSERT_NOW(a_no_pop_empty, o_cmd_pop, !i_cmd_empty, "command popped from empty queue")
    `TCJT_ASSERT_NOW(a_idx_range, r_state == S_TICK || r_state == S_ADD, r_idx <= SLOTS_C, "scan index past table")
    `TCJT_ASSERT_NOW(a_fired_range, r_state == S_TICK, r_fired <= 7'(SLOTS), "fired count past table size")
    `TCJT_ASSERT_NEXT(a_done_idle, o_res_push && o_res.last, r_state == S_IDLE, "no return to idle after final item")

endmodule

[rtl/tick_count_job_table.sv]
// Tick count job table: a table of SLOTS job counters driven by tick and
// slot commands.
// Input queue side: present i_item and raise push; the item is taken at an
// edge with push high and full low. Result side: while empty is low the
// oldest result sits on o_result; pop at an edge with empty low takes it.
// A tick yields one fired item per slot that fires, in slot order, then a
// tick done item with last set. Every other command yields one item.
// The command queue registers a command before the executor takes it, and
// the result queue registers each result before it is visible on o_result.
// A tick scans one slot per cycle through the target/count store, holding
// while a fired item waits for room in the result queue; add searches for
// the lowest free slot; delete, enable, disable need no scan.
// A two-entry command queue lets the next item in while one executes.
// Reset (synchronous, active low) frees all slots and empties both queues;
// no clearing pass is needed. When the receiver stalls, the result queue
// fills, the executor holds its place and the command queue then fills.
// Depends on tcjt_pkg, tcjt_fifo, tcjt_front and tcjt_back.
`timescale 1ns / 1ps

module tick_count_job_table #(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcjt_pkg::t_in  i_item,
    input  logic           push,
    output logic           full,
    output tcjt_pkg::t_out o_result,
    output logic           empty,
    input  logic           pop
);
    import tcjt_pkg::*;

    t_cmd front_cmd;
    logic front_push;
    logic cmdq_full;
    t_cmd cmdq_data;
    logic cmdq_empty;
    logic cmdq_pop;
    t_out back_res;
    logic back_push;
    logic resq_full;

    tcjt_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .i_item     (i_item),
        .i_push     (push),
        .o_full     (full),
        .o_cmd      (front_cmd),
        .o_cmd_push (front_push),
        .i_cmd_full (cmdq_full)
    );

    tcjt_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (cmdq_full),
        .i_pop   (cmdq_pop),
        .o_data  (cmdq_data),
        .o_empty (cmdq_empty)
    );

    tcjt_back #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmdq_data),
        .i_cmd_empty (cmdq_empty),
        .o_cmd_pop   (cmdq_pop),
        .o_res       (back_res),
        .o_res_push  (back_push),
        .i_res_full  (resq_full)
    );

    tcjt_fifo #(
        .WIDTH ($bits(t_out)),
        .DEPTH (2)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_res),
        .o_full  (resq_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule
